[hdl/acd_pkg.sv]
// Shared types and constants for the audio container deframer.
package acd_pkg;

  typedef enum logic [4:0] {
    KIND_RATE      = 5'd0,
    KIND_BITS      = 5'd1,
    KIND_CHANNELS  = 5'd2,
    KIND_FRAMES    = 5'd3,
    KIND_SYNC      = 5'd4,
    KIND_CHAN      = 5'd5,
    KIND_TYPE      = 5'd6,
    KIND_PARENT    = 5'd7,
    KIND_REFLPARAM = 5'd8,
    KIND_REFLCOUNT = 5'd9,
    KIND_ORDER     = 5'd10,
    KIND_REFLWORD  = 5'd11,
    KIND_RESPARAM  = 5'd12,
    KIND_RESCOUNT  = 5'd13,
    KIND_SAMPLES   = 5'd14,
    KIND_RESWORD   = 5'd15,
    KIND_DONE      = 5'd16,
    KIND_TOOSMALL  = 5'd17,
    KIND_BADMAGIC  = 5'd18,
    KIND_NOSYNC    = 5'd19,
    KIND_TRUNCATED = 5'd20
  } kind_t;

  localparam logic [31:0] SYNC_WORD = 32'hAA55FF00;

  // file magic, in file order
  localparam logic [7:0] MAGIC_BYTES [4] = '{8'h53, 8'h65, 8'h4C, 8'h61};

  // header layout by byte index
  localparam logic [3:0] HDR_RATE_START  = 4'd4;
  localparam logic [3:0] HDR_BITS_START  = 4'd8;
  localparam logic [3:0] HDR_CHAN_BYTE   = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [4:0]  field_kind;
    logic [31:0] field_value;
    logic [31:0] frame_number;
    logic [7:0]  channel_number;
    logic        last_of_run;
  } out_t;

  // results produced by one accepted byte
  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } push_t;

  function automatic out_t make_result(kind_t kind, logic [31:0] value,
                                       logic [31:0] fr, logic [7:0] ch);
    out_t r;
    r.field_kind     = kind;
    r.field_value    = value;
    r.frame_number   = fr;
    r.channel_number = ch;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

endpackage

[hdl/audio_container_deframer_core.sv]
// Top level: byte-serial container deframer with result queue.
// Each result word is registered into the result queue; out_data is its head.
// Throughput: one byte per cycle while each byte yields at most one word and
// out_stall stays low; bytes yielding two words can stall later bytes, since
// the single output port drains the three-entry result queue.
// Reset (rst, synchronous): parser idles until start_of_file, queue empties.
module audio_container_deframer_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  acd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output acd_pkg::out_t out_data
);

  acd_pkg::push_t push;
  logic           room;
  logic           accept;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  acd_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .in_data (in_data),
    .accept  (accept),
    .push    (push)
  );

  acd_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_en   (accept),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[hdl/acd_parser.sv]
// Byte parser: parse state registers and per-byte field assembly.
module acd_parser (
  input  logic          clk,
  input  logic          rst,
  input  acd_pkg::in_t  in_data,
  input  logic          accept,
  output acd_pkg::push_t push
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_HEADER, PH_SYNC, PH_CHAN, PH_TYPE, PH_PARENT, PH_RPARAM,
    PH_RCOUNT, PH_ORDER, PH_RWORD, PH_SPARAM, PH_SCOUNT, PH_SAMPLES,
    PH_SWORD, PH_STOPPED
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  byte_in_field, byte_in_field_next;
  logic [31:0] assembly_word, assembly_word_next;
  logic [3:0]  header_byte_count, header_byte_count_next;
  logic        magic_matched, magic_matched_next;
  logic [31:0] frames_expected, frames_expected_next;
  logic [31:0] frames_seen, frames_seen_next;
  logic [7:0]  channels_per_frame, channels_per_frame_next;
  logic [7:0]  subframe_index, subframe_index_next;
  logic [15:0] words_remaining, words_remaining_next;

  acd_pkg::out_t res [2];
  logic [1:0]    n;
  logic [31:0]   asm_val;
  logic [31:0]   byte32;
  logic          end_sub, end_frm;
  logic [31:0]   fr;
  logic [7:0]    ch;
  logic [3:0]    idx;
  logic [7:0]    b;

  always_comb begin
    b      = in_data.data_byte;
    byte32 = {24'b0, b};

    // start_of_file restarts from a clean header state
    if (in_data.start_of_file) begin
      phase_next              = PH_HEADER;
      byte_in_field_next      = '0;
      assembly_word_next      = '0;
      header_byte_count_next  = '0;
      magic_matched_next      = 1'b1;
      frames_expected_next    = '0;
      frames_seen_next        = '0;
      channels_per_frame_next = '0;
      subframe_index_next     = '0;
      words_remaining_next    = '0;
    end else begin
      phase_next              = phase;
      byte_in_field_next      = byte_in_field;
      assembly_word_next      = assembly_word;
      header_byte_count_next  = header_byte_count;
      magic_matched_next      = magic_matched;
      frames_expected_next    = frames_expected;
      frames_seen_next        = frames_seen;
      channels_per_frame_next = channels_per_frame;
      subframe_index_next     = subframe_index;
      words_remaining_next    = words_remaining;
    end

    n       = 2'd0;
    res[0]  = acd_pkg::make_result(acd_pkg::KIND_DONE, '0, '0, '0);
    res[1]  = res[0];
    end_sub = 1'b0;
    end_frm = 1'b0;
    fr      = frames_seen_next;
    ch      = subframe_index_next;
    idx     = header_byte_count_next;

    // little-endian assembly of the current field byte
    if (byte_in_field_next == 2'd0) begin
      asm_val = byte32;
    end else begin
      asm_val = assembly_word_next | (byte32 << {byte_in_field_next, 3'b000});
    end

    if (phase_next != PH_IDLE && phase_next != PH_STOPPED) begin
      unique case (phase_next)
        PH_HEADER: begin
          header_byte_count_next = 4'(idx + 4'd1);
          if (idx < acd_pkg::HDR_RATE_START) begin
            if (b != acd_pkg::MAGIC_BYTES[idx[1:0]]) magic_matched_next = 1'b0;
          end else if (idx < acd_pkg::HDR_BITS_START) begin
            assembly_word_next = asm_val;
            if (byte_in_field_next == 2'd3) begin
              byte_in_field_next = '0;
              res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_RATE, asm_val, '0, '0);
              n = 2'(n + 2'd1);
            end else begin
              byte_in_field_next = 2'(byte_in_field_next + 2'd1);
            end
          end else if (idx < acd_pkg::HDR_CHAN_BYTE) begin
            assembly_word_next = asm_val;
            if (byte_in_field_next != 2'd0) begin
              byte_in_field_next = '0;
              res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_BITS, asm_val, '0, '0);
              n = 2'(n + 2'd1);
            end else begin
              byte_in_field_next = 2'd1;
            end
          end else if (idx == acd_pkg::HDR_CHAN_BYTE) begin
            channels_per_frame_next = b;
            res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_CHANNELS, byte32, '0, '0);
            n = 2'(n + 2'd1);
          end else begin
            assembly_word_next = asm_val;
            if (byte_in_field_next == 2'd3) begin
              byte_in_field_next   = '0;
              frames_expected_next = asm_val;
              res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_FRAMES, asm_val, '0, '0);
              n = 2'(n + 2'd1);
              if (!magic_matched_next) begin
                res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_BADMAGIC, '0, '0, '0);
                n = 2'(n + 2'd1);
                phase_next = PH_STOPPED;
              end else if (asm_val == '0) begin
                res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_DONE, '0, '0, '0);
                n = 2'(n + 2'd1);
                phase_next = PH_STOPPED;
              end else begin
                phase_next = PH_SYNC;
              end
            end else begin
              byte_in_field_next = 2'(byte_in_field_next + 2'd1);
            end
          end
        end
        PH_SYNC: begin
          assembly_word_next = asm_val;
          if (byte_in_field_next == 2'd3) begin
            byte_in_field_next = '0;
            if (asm_val == acd_pkg::SYNC_WORD) begin
              res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_SYNC, asm_val, fr, '0);
              n = 2'(n + 2'd1);
              if (channels_per_frame_next == '0) end_frm = 1'b1;
              else phase_next = PH_CHAN;
            end else begin
              res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_NOSYNC, asm_val, fr, ch);
              n = 2'(n + 2'd1);
              phase_next = PH_STOPPED;
            end
          end else begin
            byte_in_field_next = 2'(byte_in_field_next + 2'd1);
          end
        end
        PH_CHAN: begin
          res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_CHAN, byte32, fr, ch);
          n = 2'(n + 2'd1);
          phase_next = PH_TYPE;
        end
        PH_TYPE: begin
          res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_TYPE, byte32, fr, ch);
          n = 2'(n + 2'd1);
          phase_next = PH_PARENT;
        end
        PH_PARENT: begin
          res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_PARENT, byte32, fr, ch);
          n = 2'(n + 2'd1);
          phase_next = PH_RPARAM;
        end
        PH_RPARAM: begin
          res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_REFLPARAM, byte32, fr, ch);
          n = 2'(n + 2'd1);
          phase_next = PH_RCOUNT;
        end
        PH_RCOUNT: begin
          assembly_word_next = asm_val;
          if (byte_in_field_next != 2'd0) begin
            byte_in_field_next   = '0;
            words_remaining_next = asm_val[15:0];
            res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_REFLCOUNT,
                                             {16'b0, asm_val[15:0]}, fr, ch);
            n = 2'(n + 2'd1);
            phase_next = PH_ORDER;
          end else begin
            byte_in_field_next = 2'd1;
          end
        end
        PH_ORDER: begin
          res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_ORDER, byte32, fr, ch);
          n = 2'(n + 2'd1);
          phase_next = (words_remaining_next != '0) ? PH_RWORD : PH_SPARAM;
        end
        PH_RWORD: begin
          assembly_word_next = asm_val;
          if (byte_in_field_next == 2'd3) begin
            byte_in_field_next = '0;
            res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_REFLWORD, asm_val, fr, ch);
            n = 2'(n + 2'd1);
            words_remaining_next = 16'(words_remaining_next - 16'd1);
            if (words_remaining_next == '0) phase_next = PH_SPARAM;
          end else begin
            byte_in_field_next = 2'(byte_in_field_next + 2'd1);
          end
        end
        PH_SPARAM: begin
          res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_RESPARAM, byte32, fr, ch);
          n = 2'(n + 2'd1);
          phase_next = PH_SCOUNT;
        end
        PH_SCOUNT: begin
          assembly_word_next = asm_val;
          if (byte_in_field_next != 2'd0) begin
            byte_in_field_next   = '0;
            words_remaining_next = asm_val[15:0];
            res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_RESCOUNT,
                                             {16'b0, asm_val[15:0]}, fr, ch);
            n = 2'(n + 2'd1);
            phase_next = PH_SAMPLES;
          end else begin
            byte_in_field_next = 2'd1;
          end
        end
        PH_SAMPLES: begin
          assembly_word_next = asm_val;
          if (byte_in_field_next != 2'd0) begin
            byte_in_field_next = '0;
            res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_SAMPLES,
                                             {16'b0, asm_val[15:0]}, fr, ch);
            n = 2'(n + 2'd1);
            if (words_remaining_next != '0) phase_next = PH_SWORD;
            else end_sub = 1'b1;
          end else begin
            byte_in_field_next = 2'd1;
          end
        end
        PH_SWORD: begin
          assembly_word_next = asm_val;
          if (byte_in_field_next == 2'd3) begin
            byte_in_field_next = '0;
            res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_RESWORD, asm_val, fr, ch);
            n = 2'(n + 2'd1);
            words_remaining_next = 16'(words_remaining_next - 16'd1);
            if (words_remaining_next == '0) end_sub = 1'b1;
          end else begin
            byte_in_field_next = 2'(byte_in_field_next + 2'd1);
          end
        end
        default: phase_next = PH_STOPPED;
      endcase

      if (end_sub) begin
        subframe_index_next = 8'(subframe_index_next + 8'd1);
        if (subframe_index_next == channels_per_frame_next) end_frm = 1'b1;
        else phase_next = PH_CHAN;
      end

      if (end_frm) begin
        frames_seen_next    = 32'(frames_seen_next + 32'd1);
        subframe_index_next = '0;
        if (frames_seen_next == frames_expected_next) begin
          res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_DONE, frames_seen_next,
                                           frames_seen_next, '0);
          n = 2'(n + 2'd1);
          phase_next = PH_STOPPED;
        end else begin
          phase_next = PH_SYNC;
        end
      end

      if (in_data.end_of_file && phase_next != PH_STOPPED) begin
        if (phase_next == PH_HEADER) begin
          res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_TOOSMALL,
                                           {28'b0, header_byte_count_next},
                                           frames_seen_next, subframe_index_next);
        end else begin
          res[n[0]] = acd_pkg::make_result(acd_pkg::KIND_TRUNCATED, '0,
                                           frames_seen_next, subframe_index_next);
        end
        n = 2'(n + 2'd1);
        phase_next = PH_STOPPED;
      end
    end

    if (n == 2'd2) res[1].last_of_run = 1'b1;
    else res[0].last_of_run = 1'b1;

    push.count  = n;
    push.first  = res[0];
    push.second = res[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      byte_in_field      <= '0;
      assembly_word      <= '0;
      header_byte_count  <= '0;
      magic_matched      <= 1'b1;
      frames_expected    <= '0;
      frames_seen        <= '0;
      channels_per_frame <= '0;
      subframe_index     <= '0;
      words_remaining    <= '0;
    end else if (accept) begin
      phase              <= phase_next;
      byte_in_field      <= byte_in_field_next;
      assembly_word      <= assembly_word_next;
      header_byte_count  <= header_byte_count_next;
      magic_matched      <= magic_matched_next;
      frames_expected    <= frames_expected_next;
      frames_seen        <= frames_seen_next;
      channels_per_frame <= channels_per_frame_next;
      subframe_index     <= subframe_index_next;
      words_remaining    <= words_remaining_next;
    end
  end

endmodule

[hdl/acd_result_queue.sv]
// Three-entry result queue; head entry is the output register.
module acd_result_queue (
  input  logic           clk,
  input  logic           rst,
  input  acd_pkg::push_t push,
  input  logic           push_en,
  output logic           room,
  output logic           out_valid,
  input  logic           out_stall,
  output acd_pkg::out_t  out_data
);

  acd_pkg::out_t entry [3];
  acd_pkg::out_t entry_next [3];
  logic [1:0]    count, count_next;
  logic [1:0]    base;
  logic [1:0]    add;
  logic          pop;

  assign out_valid = (count != 2'd0);
  assign out_data  = entry[0];
  assign pop       = out_valid && !out_stall;
  assign base      = 2'(count - {1'b0, pop});
  // a byte may produce two words, so keep two slots free
  assign room      = (base <= 2'd1);
  assign add       = push_en ? push.count : 2'd0;

  always_comb begin
    entry_next[0] = pop ? entry[1] : entry[0];
    entry_next[1] = pop ? entry[2] : entry[1];
    entry_next[2] = entry[2];
    if (add != 2'd0) entry_next[base] = push.first;
    if (add == 2'd2) entry_next[2'(base + 2'd1)] = push.second;
    count_next = 2'(base + add);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
